FILE: rtl/core/rmc_pkg.sv
// ----------------------------------------------------------------------------
// rmc_pkg
// Types, MD5 constants and message helpers shared by the checksum pipeline.
// ----------------------------------------------------------------------------
package rmc_pkg;

   // one record as it arrives on the request channel
   typedef struct packed {
      logic [63:0] record_id;
      logic [7:0]  level;
      logic [31:0] experience;
      logic [63:0] coin_amount;
      logic [63:0] stored_coin_amount;
   } record_type;

   // working state carried from one round stage to the next
   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
      logic [31:0] d;
      logic [31:0] h0_mid;
      record_type  rec;
   } state_type;

   localparam int NUM_ROUNDS  = 64;
   localparam int NUM_STEPS   = 2 * NUM_ROUNDS;
   localparam int MSG_BYTES   = 58;
   localparam int RECORD_BITS = $bits(record_type);

   localparam logic [31:0] IV_A = 32'h67452301;
   localparam logic [31:0] IV_B = 32'hefcdab89;
   localparam logic [31:0] IV_C = 32'h98badcfe;
   localparam logic [31:0] IV_D = 32'h10325476;

   // message length in bits, the only nonzero word of the second block
   localparam logic [31:0] MSG_BITS   = 32'(MSG_BYTES * 8);
   localparam int          LEN_WORD   = 14;
   localparam logic [7:0]  PAD_BYTE   = 8'h80;

   localparam logic [31:0] MD_K [NUM_ROUNDS] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   localparam int MD_S [16] = '{
      7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
   };

   // rotate amount of a round
   function automatic int shift_amt(input int r);
      return MD_S[((r / 16) * 4) + (r % 4)];
   endfunction

   // message word index of a round
   function automatic int msg_index(input int r);
      int grp;
      grp = r / 16;
      case (grp)
         0:       return r;
         1:       return (5 * r + 1) % 16;
         2:       return (3 * r + 5) % 16;
         default: return (7 * r) % 16;
      endcase
   endfunction

   // lower-case ASCII of one hex digit
   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      if (nib < 4'd10) begin
         return 8'h30 + {4'h0, nib};
      end else begin
         return 8'h57 + {4'h0, nib};
      end
   endfunction

   // byte of the first block: hex text, then the pad marker, then zeros
   function automatic logic [7:0] block0_byte(input record_type rec, input int j);
      logic [RECORD_BITS-1:0] bits;
      bits = rec;
      if (j < MSG_BYTES) begin
         return hex_char(bits[RECORD_BITS-1-4*j -: 4]);
      end else if (j == MSG_BYTES) begin
         return PAD_BYTE;
      end else begin
         return 8'h00;
      end
   endfunction

   // little-endian message word of the first block
   function automatic logic [31:0] block0_word(input record_type rec, input int g);
      return {block0_byte(rec, 4*g+3), block0_byte(rec, 4*g+2),
              block0_byte(rec, 4*g+1), block0_byte(rec, 4*g)};
   endfunction

   // message word of the second block: zeros and the bit length
   function automatic logic [31:0] block1_word(input int g);
      return (g == LEN_WORD) ? MSG_BITS : 32'h0;
   endfunction

endpackage

FILE: rtl/core/rmc_if.sv
// ----------------------------------------------------------------------------
// rmc_req_if / rmc_rsp_if
// Valid/ready channels for records in and checksums out.
// ----------------------------------------------------------------------------
interface rmc_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] record_id;
   logic [7:0]  level;
   logic [31:0] experience;
   logic [63:0] coin_amount;
   logic [63:0] stored_coin_amount;

   modport source (output valid, record_id, level, experience, coin_amount,
                   stored_coin_amount, input ready);
   modport sink   (input valid, record_id, level, experience, coin_amount,
                   stored_coin_amount, output ready);
endinterface

interface rmc_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] checksum;

   modport source (output valid, checksum, input ready);
   modport sink   (input valid, checksum, output ready);
endinterface

FILE: rtl/core/rmc_round.sv
// ----------------------------------------------------------------------------
// rmc_round
// One MD5 step as a register stage; STEP below 64 works on the text block,
// from 64 on the constant length block.
// ----------------------------------------------------------------------------
module rmc_round import rmc_pkg::*; #(
   parameter int STEP = 0
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      advance,
   input  logic      valid_i,
   input  state_type state_i,
   output logic      valid_o,
   output state_type state_o
);

   localparam int          R  = STEP % NUM_ROUNDS;
   localparam int          G  = msg_index(R);
   localparam int          SH = shift_amt(R);
   localparam logic [31:0] KV = MD_K[R];

   logic        valid_ff;
   state_type   state_ff;
   state_type   state_in;
   logic [31:0] m_word;
   logic [31:0] f_val;
   logic [31:0] sum;
   logic [31:0] rot;

   // pick the message word and the round function
   always_comb begin
      m_word = (STEP < NUM_ROUNDS) ? block0_word(state_i.rec, G) : block1_word(G);
      case (R / 16)
         0:       f_val = (state_i.b & state_i.c) | (~state_i.b & state_i.d);
         1:       f_val = (state_i.d & state_i.b) | (~state_i.d & state_i.c);
         2:       f_val = state_i.b ^ state_i.c ^ state_i.d;
         default: f_val = state_i.c ^ (state_i.b | ~state_i.d);
      endcase
      sum      = f_val + state_i.a + KV + m_word;
      rot      = (sum << SH) | (sum >> (32 - SH));
      state_in = state_i;
      state_in.a = state_i.d;
      state_in.d = state_i.c;
      state_in.c = state_i.b;
      state_in.b = state_i.b + rot;
   end

   // advance the stage when the pipe moves
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_i;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         state_ff <= state_in;
      end
   end

   assign valid_o = valid_ff;
   assign state_o = state_ff;

endmodule

FILE: rtl/core/record_md5_checksum.sv
// ----------------------------------------------------------------------------
// record_md5_checksum
// MD5 of a record's hex text (two blocks), first four digest bytes out.
// ----------------------------------------------------------------------------
// Channel   Dir  Content
// req_chan  in   record_id, level, experience, coin_amount, stored_coin_amount
// rsp_chan  out  checksum
//
// One request enters per cycle while the response is not stalled; each passes
// 130 register stages: 64 round stages for the text block, one chaining-add
// stage, 64 round stages for the length block, and the output register.
// Reset clears every stage valid bit; payload registers are not reset.
// A stalled response freezes the whole pipe; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module record_md5_checksum import rmc_pkg::*; (
   input logic     clock,
   input logic     reset,
   rmc_req_if.sink   req_chan,
   rmc_rsp_if.source rsp_chan
);

   logic                 advance;
   logic [NUM_STEPS+1:0] valid;
   state_type            state [NUM_STEPS+2];
   state_type            mid_in;
   logic                 mid_valid_ff;
   state_type            mid_ff;
   logic                 rsp_valid_ff;
   logic [31:0]          checksum_ff;
   logic [31:0]          checksum_in;
   logic [31:0]          h0;

   // move the pipe unless the output holds an untaken response
   assign advance       = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = advance;

   // load the initial chaining values with the request
   always_comb begin
      valid[0]        = req_chan.valid;
      state[0].a      = IV_A;
      state[0].b      = IV_B;
      state[0].c      = IV_C;
      state[0].d      = IV_D;
      state[0].h0_mid = IV_A;
      state[0].rec    = '{req_chan.record_id, req_chan.level, req_chan.experience,
                          req_chan.coin_amount, req_chan.stored_coin_amount};
   end

   // rounds of the text block
   for (genvar i = 0; i < NUM_ROUNDS; i++) begin : g_blk0
      rmc_round #(.STEP(i)) u_round (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .valid_i (valid[i]),
         .state_i (state[i]),
         .valid_o (valid[i+1]),
         .state_o (state[i+1])
      );
   end

   // chain: add the initial values after the first block
   always_comb begin
      mid_in        = state[NUM_ROUNDS];
      mid_in.a      = state[NUM_ROUNDS].a + IV_A;
      mid_in.b      = state[NUM_ROUNDS].b + IV_B;
      mid_in.c      = state[NUM_ROUNDS].c + IV_C;
      mid_in.d      = state[NUM_ROUNDS].d + IV_D;
      mid_in.h0_mid = state[NUM_ROUNDS].a + IV_A;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_valid_ff <= 1'b0;
      end else if (advance) begin
         mid_valid_ff <= valid[NUM_ROUNDS];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mid_ff <= mid_in;
      end
   end

   assign valid[NUM_ROUNDS+1] = mid_valid_ff;
   assign state[NUM_ROUNDS+1] = mid_ff;

   // rounds of the length block
   for (genvar i = NUM_ROUNDS; i < NUM_STEPS; i++) begin : g_blk1
      rmc_round #(.STEP(i)) u_round (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .valid_i (valid[i+1]),
         .state_i (state[i+1]),
         .valid_o (valid[i+2]),
         .state_o (state[i+2])
      );
   end

   // finish the first digest word and swap to big-endian
   assign h0          = state[NUM_STEPS+1].h0_mid + state[NUM_STEPS+1].a;
   assign checksum_in = {h0[7:0], h0[15:8], h0[23:16], h0[31:24]};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= valid[NUM_STEPS+1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         checksum_ff <= checksum_in;
      end
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.checksum = checksum_ff;

   // a stall freezes every stage valid bit ahead of the output register
   a_stall_hold : assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(valid[NUM_STEPS+1:1]))
      else $error("stage valid changed during stall");

   // an accepted request shows up in the first stage
   a_enter : assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> valid[1])
      else $error("accepted request missing from first stage");

   // the pipe moves exactly when the output can take a result
   a_ready : assert property (@(posedge clock) disable iff (reset)
      req_chan.ready == (!rsp_chan.valid || rsp_chan.ready))
      else $error("ready does not track output stall");

   // reset empties the output
   a_reset : assert property (@(posedge clock) reset |=> !rsp_chan.valid)
      else $error("response valid after reset");

endmodule

FILE: verif/checksum_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// checksum_checker
// Watches the record and checksum channels, computes the MD5 checksum of
// every accepted record and compares it with the next checksum delivered.
// ----------------------------------------------------------------------------
module checksum_checker import rmc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   rmc_req_if.sink   req_mon,
   rmc_rsp_if.source rsp_mon,
   output int        fail_count,
   output int        pending_count,
   output int        request_count,
   output int        checksum_count
);

   logic [31:0] checksum_queue[$];
   int          mismatch_count;

   // lower-case ASCII of one hex digit
   function automatic logic [7:0] ascii_nibble(input logic [3:0] nib);
      if (nib < 4'd10) begin
         return 8'h30 + {4'h0, nib};
      end
      return 8'h61 + {4'h0, nib - 4'd10};
   endfunction

   function automatic logic [31:0] left_rotate(input logic [31:0] x, input int s);
      return (x << s) | (x >> (32 - s));
   endfunction

   // one MD5 compression over sixteen little-endian words
   function automatic void md5_compress(inout logic [31:0] chain[4],
                                        input logic [31:0] words[16]);
      logic [31:0] a, b, c, d, f;
      int          g, grp;
      logic [31:0] k_tab[64];
      int          s_tab[16];
      k_tab = '{
         32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
         32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
         32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
         32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
         32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
         32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
         32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
         32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
         32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
         32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
         32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
         32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
         32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
         32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
         32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
         32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
      s_tab = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
      a = chain[0];
      b = chain[1];
      c = chain[2];
      d = chain[3];
      for (int i = 0; i < 64; i++) begin
         grp = i / 16;
         case (grp)
            0: begin
               f = (b & c) | (~b & d);
               g = i;
            end
            1: begin
               f = (d & b) | (~d & c);
               g = (5 * i + 1) % 16;
            end
            2: begin
               f = b ^ c ^ d;
               g = (3 * i + 5) % 16;
            end
            default: begin
               f = c ^ (b | ~d);
               g = (7 * i) % 16;
            end
         endcase
         f = f + a + k_tab[i] + words[g];
         a = d;
         d = c;
         c = b;
         b = b + left_rotate(f, s_tab[grp * 4 + i % 4]);
      end
      chain[0] += a;
      chain[1] += b;
      chain[2] += c;
      chain[3] += d;
   endfunction

   // hash the 58-character hex text of a record, return digest bytes 0..3
   function automatic logic [31:0] record_checksum(input record_type rec);
      logic [231:0] fields;
      logic [7:0]   text[128];
      logic [31:0]  words[16];
      logic [31:0]  chain[4];
      fields = {rec.record_id, rec.level, rec.experience, rec.coin_amount,
                rec.stored_coin_amount};
      foreach (text[j]) text[j] = 8'h00;
      for (int j = 0; j < 58; j++) begin
         text[j] = ascii_nibble(fields[231 - 4 * j -: 4]);
      end
      text[58] = 8'h80;
      text[120] = 8'(58 * 8 & 8'hff);
      text[121] = 8'((58 * 8) >> 8);
      chain = '{32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476};
      for (int blk = 0; blk < 2; blk++) begin
         for (int w = 0; w < 16; w++) begin
            words[w] = {text[64*blk+4*w+3], text[64*blk+4*w+2],
                        text[64*blk+4*w+1], text[64*blk+4*w]};
         end
         md5_compress(chain, words);
      end
      return {chain[0][7:0], chain[0][15:8], chain[0][23:16], chain[0][31:24]};
   endfunction

   assign fail_count    = mismatch_count;
   assign pending_count = checksum_queue.size();

   // predict on every accepted request, check every accepted checksum
   always @(posedge clock) begin
      logic [31:0] want;
      record_type  rec;
      if (reset) begin
         checksum_queue.delete();
         mismatch_count <= 0;
         request_count  <= 0;
         checksum_count <= 0;
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            rec.record_id          = req_mon.record_id;
            rec.level              = req_mon.level;
            rec.experience         = req_mon.experience;
            rec.coin_amount        = req_mon.coin_amount;
            rec.stored_coin_amount = req_mon.stored_coin_amount;
            checksum_queue = {checksum_queue, record_checksum(rec)};
            request_count <= request_count + 1;
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            checksum_count <= checksum_count + 1;
            if (checksum_queue.size() == 0) begin
               if (mismatch_count < 10)
                  $display("checker: unexpected checksum %h", rsp_mon.checksum);
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = checksum_queue.pop_front();
               if (want !== rsp_mon.checksum) begin
                  if (mismatch_count < 10)
                     $display("checker: checksum expected %h got %h",
                              want, rsp_mon.checksum);
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
      end
   end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives records into the checksum pipeline in bursts with gaps, stalls the
// checksum output on its own pattern, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module testbench;
   import rmc_pkg::*;

   localparam int RANDOM_RECORDS = 1150;
   localparam int IDLE_LIMIT     = 5000;

   logic clock;
   logic reset;
   int   fail_count, pending_count, request_count, checksum_count;
   int   idle_cycles;
   bit   timed_out;

   rmc_req_if req_chan ();
   rmc_rsp_if rsp_chan ();

   record_md5_checksum u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   checksum_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_chan),
      .rsp_mon        (rsp_chan),
      .fail_count     (fail_count),
      .pending_count  (pending_count),
      .request_count  (request_count),
      .checksum_count (checksum_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver stall pattern: runs of ready and not ready, sometimes none
   initial begin
      int run;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!reset && $urandom_range(0, 9) == 0) begin
            run = $urandom_range(1, 12);
            rsp_chan.ready <= 1'b0;
            repeat (run) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         if ($urandom_range(0, 3) == 0) repeat ($urandom_range(20, 200)) @(negedge clock);
      end
   end

   // watchdog on cycles without any accepted transfer
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) ||
          (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("tb: failure");
            $finish;
         end
      end
   end

   // present one request and hold until accepted
   task automatic send_record(input logic [63:0] id, input logic [7:0] lvl,
                              input logic [31:0] exp_v, input logic [63:0] coins,
                              input logic [63:0] stored);
      req_chan.valid              <= 1'b1;
      req_chan.record_id          <= id;
      req_chan.level              <= lvl;
      req_chan.experience         <= exp_v;
      req_chan.coin_amount        <= coins;
      req_chan.stored_coin_amount <= stored;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [63:0] random_wide();
      case ($urandom_range(0, 5))
         0:       return 64'h0;
         1:       return '1;
         2:       return 64'h8000_0000_0000_0000;
         3:       return 64'h7fff_ffff_ffff_ffff;
         4:       return {32'h0, $urandom};
         default: return {$urandom, $urandom};
      endcase
   endfunction

   initial begin
      int sent, burst;
      timed_out      = 1'b0;
      idle_cycles    = 0;
      reset          = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.record_id          = '0;
      req_chan.level              = '0;
      req_chan.experience         = '0;
      req_chan.coin_amount        = '0;
      req_chan.stored_coin_amount = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: zeros, all ones, sign extremes, digit patterns
      send_record('0, 8'h00, 32'h0, '0, '0);
      send_record('1, 8'hff, 32'hffff_ffff, '1, '1);
      send_record(64'h8000_0000_0000_0000, 8'h80, 32'h8000_0000,
                  64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000);
      send_record(64'h7fff_ffff_ffff_ffff, 8'h7f, 32'h7fff_ffff,
                  64'h7fff_ffff_ffff_ffff, 64'h7fff_ffff_ffff_ffff);
      send_record(64'h0123_4567_89ab_cdef, 8'h9a, 32'hfedc_ba98,
                  64'hffff_ffff_ffff_ff9c, 64'h0000_0000_0000_0064);
      send_record(64'h1, 8'h01, 32'hffff_fffe, 64'h5555_5555_5555_5555,
                  64'haaaa_aaaa_aaaa_aaaa);
      send_record(64'hffff_ffff_ffff_fffe, 8'h0a, 32'h0000_000f,
                  64'h0, 64'hffff_ffff_ffff_ffff);
      req_chan.valid <= 1'b0;

      // hold off until the pipe has drained
      while (pending_count != 0) @(negedge clock);

      // random bursts with random gaps
      sent = 0;
      while (sent < RANDOM_RECORDS) begin
         burst = $urandom_range(1, 40);
         for (int i = 0; i < burst && sent < RANDOM_RECORDS; i++) begin
            send_record(random_wide(), 8'($urandom), $urandom, random_wide(),
                        random_wide());
            sent++;
         end
         req_chan.valid <= 1'b0;
         if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 15)) @(negedge clock);
      end
      req_chan.valid <= 1'b0;

      // drain, then allow for pipeline latency
      while (pending_count != 0) @(negedge clock);
      repeat (200) @(negedge clock);

      $display("tb: %0d records sent, %0d checksums checked, extremes and random",
               request_count, checksum_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
